// File: rtl/hte_pkg.sv
package hte_pkg;

	localparam int FUNC_W    = 3;
	localparam int IDX_W     = 4;
	localparam int DATA_W    = 32;
	localparam int DIM       = 4;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 2 * DATA_W;
	// four full products summed exactly
	localparam int ACC_W     = PROD_W + 2;

	localparam logic [FUNC_W-1:0] FUNC_LOAD_M    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_F    = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_IDENT     = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_COMPOSE   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_TRANSFORM = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd5;

	typedef logic signed [DATA_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	localparam coord_t Q_ONE = coord_t'(1) <<< FRAC_BITS;
	localparam coord_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam coord_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam acc_t   SAT_HI = {{(ACC_W-DATA_W){1'b0}}, Q_MAX};
	localparam acc_t   SAT_LO = {{(ACC_W-DATA_W){1'b1}}, Q_MIN};

	typedef struct packed {
		logic take;     // input transfer this cycle
		logic mul;      // issue one multiply step on all lanes
		logic first;    // first step of a dot product
		logic fin;      // accumulators complete: write back
		logic publish;  // move result into the output register
	} hte_cmd_t;

endpackage

// File: rtl/hte_req_if.sv
interface hte_req_if;
	import hte_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [IDX_W-1:0]    elem_index;
	coord_t              elem_value;
	coord_t              in_x;
	coord_t              in_y;
	coord_t              in_z;
	coord_t              in_w;

	modport source (
		output valid, func, elem_index, elem_value, in_x, in_y, in_z, in_w,
		input  ready
	);
	modport sink (
		input  valid, func, elem_index, elem_value, in_x, in_y, in_z, in_w,
		output ready
	);

endinterface

// File: rtl/hte_rsp_if.sv
interface hte_rsp_if;
	import hte_pkg::*;

	logic   valid;
	logic   ready;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	coord_t out_w;
	logic   saturated;

	modport source (
		output valid, out_x, out_y, out_z, out_w, saturated,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_z, out_w, saturated,
		output ready
	);

endinterface

// File: rtl/homogeneous_transform_engine.sv
// 4x4 homogeneous transform engine, signed Q16.16. One request in, one response out.
// Loads, identity, read and unused codes go from the transfer straight to the done state.
// In a point transform four lane multipliers step through the four columns of the
// matrix, then the multiply and accumulate stages drain before the write back.
// Compose makes one such pass per column of the new matrix.
// A new request is taken only once the previous one has reached the output
// register; it may be taken while that result still waits for its transfer.
// After reset the matrix is identity and the factor matrix is zero.
module homogeneous_transform_engine (
	input logic       clk,
	input logic       arst_n,
	hte_req_if.sink   req,
	hte_rsp_if.source rsp
);
	import hte_pkg::*;

	hte_cmd_t dp_cmd;

	hte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_func  (req.func),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (dp_cmd)
	);

	hte_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.func       (req.func),
		.elem_index (req.elem_index),
		.elem_value (req.elem_value),
		.in_x       (req.in_x),
		.in_y       (req.in_y),
		.in_z       (req.in_z),
		.in_w       (req.in_w),
		.out_x      (rsp.out_x),
		.out_y      (rsp.out_y),
		.out_z      (rsp.out_z),
		.out_w      (rsp.out_w),
		.saturated  (rsp.saturated)
	);

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.publish |-> (!rsp.valid || rsp.ready))
		else $error("result published over a pending response");

	a_take_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.take |-> (!dp_cmd.mul && !dp_cmd.fin && !dp_cmd.publish))
		else $error("request taken while datapath busy");

	a_fin_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.fin |-> $past(dp_cmd.mul, 2) && !$past(dp_cmd.mul, 1))
		else $error("write back without completed accumulation");

endmodule

// File: rtl/hte_ctrl.sv
module hte_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [hte_pkg::FUNC_W-1:0]  req_func,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output hte_pkg::hte_cmd_t           cmd
);
	import hte_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [1:0] step_q;
	logic [1:0] col_q;
	logic       compose_q;
	logic       rsp_valid_q;
	logic       accept;
	logic       out_free;
	logic       long_op;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign long_op   = (req_func == FUNC_COMPOSE) || (req_func == FUNC_TRANSFORM);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.take    = accept;
		cmd.mul     = (state_q == S_MUL);
		cmd.first   = (state_q == S_MUL) && (step_q == 2'd0);
		cmd.fin     = (state_q == S_FIN);
		cmd.publish = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			col_q       <= '0;
			compose_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.publish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q    <= '0;
						col_q     <= '0;
						compose_q <= (req_func == FUNC_COMPOSE);
						state_q   <= long_op ? S_MUL : S_DONE;
					end
				end
				S_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_FIN;
				S_FIN: begin
					// compose walks all four columns
					if (compose_q && col_q != 2'd3) begin
						col_q   <= col_q + 2'd1;
						step_q  <= '0;
						state_q <= S_MUL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/hte_datapath.sv
module hte_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hte_pkg::hte_cmd_t           cmd,
	input  logic [hte_pkg::FUNC_W-1:0]  func,
	input  logic [hte_pkg::IDX_W-1:0]   elem_index,
	input  hte_pkg::coord_t             elem_value,
	input  hte_pkg::coord_t             in_x,
	input  hte_pkg::coord_t             in_y,
	input  hte_pkg::coord_t             in_z,
	input  hte_pkg::coord_t             in_w,
	output hte_pkg::coord_t             out_x,
	output hte_pkg::coord_t             out_y,
	output hte_pkg::coord_t             out_z,
	output hte_pkg::coord_t             out_w,
	output logic                        saturated
);
	import hte_pkg::*;

	// stored as [column][row]
	coord_t coeff_q  [DIM][DIM];
	coord_t factor_q [DIM][DIM];
	coord_t pt_q     [DIM];
	logic   compose_q;

	coord_t a_op [DIM];
	coord_t b_op;
	prod_t  prod_s1 [DIM];
	logic   mul_s1;
	logic   first_s1;
	acc_t   acc_q   [DIM];
	acc_t   acc_sh  [DIM];
	coord_t lane_val [DIM];
	logic [DIM-1:0] lane_sat;

	coord_t res_q [DIM];
	logic   sat_q;
	coord_t out_q [DIM];
	logic   out_sat_q;

	// head column and head element feed the lanes; the rest rotate past
	always_comb begin
		b_op = compose_q ? coeff_q[0][0] : pt_q[0];
		for (int r = 0; r < DIM; r++) begin
			a_op[r] = compose_q ? factor_q[0][r] : coeff_q[0][r];
		end
	end

	always_comb begin
		for (int r = 0; r < DIM; r++) begin
			acc_sh[r]   = acc_q[r] >>> FRAC_BITS;
			lane_sat[r] = (acc_sh[r] > SAT_HI) || (acc_sh[r] < SAT_LO);
			if (acc_sh[r] > SAT_HI) begin
				lane_val[r] = Q_MAX;
			end else if (acc_sh[r] < SAT_LO) begin
				lane_val[r] = Q_MIN;
			end else begin
				lane_val[r] = acc_sh[r][DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < DIM; c++) begin
				for (int r = 0; r < DIM; r++) begin
					coeff_q[c][r]  <= (c == r) ? Q_ONE : '0;
					factor_q[c][r] <= '0;
				end
			end
		end else if (cmd.take) begin
			case (func)
				FUNC_LOAD_M: coeff_q[elem_index[3:2]][elem_index[1:0]] <= elem_value;
				FUNC_LOAD_F: factor_q[elem_index[3:2]][elem_index[1:0]] <= elem_value;
				FUNC_IDENT: begin
					for (int c = 0; c < DIM; c++) begin
						for (int r = 0; r < DIM; r++) begin
							coeff_q[c][r] <= (c == r) ? Q_ONE : '0;
						end
					end
				end
				default: ;
			endcase
		end else if (cmd.mul) begin
			if (compose_q) begin
				for (int c = 0; c < DIM-1; c++) begin
					factor_q[c] <= factor_q[c+1];
				end
				factor_q[DIM-1] <= factor_q[0];
				for (int r = 0; r < DIM-1; r++) begin
					coeff_q[0][r] <= coeff_q[0][r+1];
				end
				coeff_q[0][DIM-1] <= coeff_q[0][0];
			end else begin
				for (int c = 0; c < DIM-1; c++) begin
					coeff_q[c] <= coeff_q[c+1];
				end
				coeff_q[DIM-1] <= coeff_q[0];
			end
		end else if (cmd.fin && compose_q) begin
			// head column is done: drop it and append the new column
			for (int c = 0; c < DIM-1; c++) begin
				coeff_q[c] <= coeff_q[c+1];
			end
			for (int r = 0; r < DIM; r++) begin
				coeff_q[DIM-1][r] <= lane_val[r];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_s1    <= 1'b0;
			first_s1  <= 1'b0;
			compose_q <= 1'b0;
		end else begin
			mul_s1   <= cmd.mul;
			first_s1 <= cmd.first;
			if (cmd.take) begin
				compose_q <= (func == FUNC_COMPOSE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pt_q[0] <= in_x;
			pt_q[1] <= in_y;
			pt_q[2] <= in_z;
			pt_q[3] <= in_w;
		end else if (cmd.mul) begin
			for (int k = 0; k < DIM-1; k++) begin
				pt_q[k] <= pt_q[k+1];
			end
			pt_q[DIM-1] <= pt_q[0];
		end

		if (cmd.mul) begin
			for (int r = 0; r < DIM; r++) begin
				prod_s1[r] <= prod_t'(a_op[r]) * prod_t'(b_op);
			end
		end

		if (mul_s1) begin
			for (int r = 0; r < DIM; r++) begin
				acc_q[r] <= (first_s1 ? acc_t'(0) : acc_q[r]) + acc_t'(prod_s1[r]);
			end
		end

		if (cmd.take) begin
			res_q[0] <= (func == FUNC_READ) ?
				coeff_q[elem_index[3:2]][elem_index[1:0]] : '0;
			for (int r = 1; r < DIM; r++) begin
				res_q[r] <= '0;
			end
			sat_q <= 1'b0;
		end else if (cmd.fin) begin
			if (!compose_q) begin
				res_q <= lane_val;
			end
			sat_q <= sat_q | (|lane_sat);
		end

		if (cmd.publish) begin
			out_q     <= res_q;
			out_sat_q <= sat_q;
		end
	end

	assign out_x     = out_q[0];
	assign out_y     = out_q[1];
	assign out_z     = out_q[2];
	assign out_w     = out_q[3];
	assign saturated = out_sat_q;

endmodule

// File: sim/tb_homogeneous_transform_engine.sv
module tb_homogeneous_transform_engine;
	timeunit 1ns;
	timeprecision 1ps;
	import hte_pkg::*;

	localparam int RANDOM_ITEMS   = 1550;
	localparam int DRAIN_EVERY    = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int COEF_SPAN      = 1 << 17;
	localparam int POINT_SPAN     = 1 << 24;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED_7 = 3'd7;

	typedef logic signed [ACC_W-1:0] dot_sum_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  idx;
		coord_t            value;
		coord_t            x;
		coord_t            y;
		coord_t            z;
		coord_t            w;
	} xf_req_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t w;
		logic   sat;
	} xf_rsp_t;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HOLD, STALL_TOGGLE} stall_mode_t;

	class xform_scoreboard;
		coord_t  matrix[16];
		coord_t  factor[16];
		xf_rsp_t expected_q[$];
		int      mismatches;

		function new();
			mismatches = 0;
			set_identity();
			foreach (factor[i]) factor[i] = '0;
		endfunction

		function void set_identity();
			foreach (matrix[i]) matrix[i] = (i % 5 == 0) ? Q_ONE : '0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Exact four-term sum, floor shift, then clamp to the 32-bit range.
		function coord_t fixed_dot(input coord_t a[4], input coord_t b[4], inout logic clamped);
			dot_sum_t sum;
			sum = '0;
			for (int k = 0; k < 4; k++)
				sum += dot_sum_t'(a[k]) * dot_sum_t'(b[k]);
			sum = sum >>> FRAC_BITS;
			if (sum > dot_sum_t'(Q_MAX)) begin
				clamped = 1'b1;
				return Q_MAX;
			end
			if (sum < dot_sum_t'(Q_MIN)) begin
				clamped = 1'b1;
				return Q_MIN;
			end
			return coord_t'(sum);
		endfunction

		function void note_request(xf_req_t r);
			xf_rsp_t want;
			coord_t  row[4];
			coord_t  col[4];
			coord_t  res[4];
			coord_t  composed[16];
			logic    clamped;
			want = '0;
			clamped = 1'b0;
			case (r.func)
				FUNC_LOAD_M: matrix[r.idx] = r.value;
				FUNC_LOAD_F: factor[r.idx] = r.value;
				FUNC_IDENT: set_identity();
				FUNC_COMPOSE: begin
					// new matrix = factor * matrix, column by column
					for (int c = 0; c < 4; c++) begin
						for (int rr = 0; rr < 4; rr++) begin
							for (int k = 0; k < 4; k++) begin
								row[k] = factor[rr + 4 * k];
								col[k] = matrix[4 * c + k];
							end
							composed[4 * c + rr] = fixed_dot(row, col, clamped);
						end
					end
					matrix = composed;
				end
				FUNC_TRANSFORM: begin
					col = '{r.x, r.y, r.z, r.w};
					for (int rr = 0; rr < 4; rr++) begin
						for (int k = 0; k < 4; k++)
							row[k] = matrix[rr + 4 * k];
						res[rr] = fixed_dot(row, col, clamped);
					end
					want.x = res[0];
					want.y = res[1];
					want.z = res[2];
					want.w = res[3];
				end
				FUNC_READ: want.x = matrix[r.idx];
				default: ;
			endcase
			want.sat = clamped;
			expected_q.push_back(want);
		endfunction

		task report(string msg);
			mismatches++;
			$display("%0t: mismatch: %s", $realtime, msg);
		endtask

		task check_response(xf_rsp_t got);
			xf_rsp_t want;
			if (expected_q.size() == 0) begin
				report("response transfer with no request outstanding");
				return;
			end
			want = expected_q.pop_front();
			if (got.x !== want.x)
				report($sformatf("out_x got %h want %h", got.x, want.x));
			if (got.y !== want.y)
				report($sformatf("out_y got %h want %h", got.y, want.y));
			if (got.z !== want.z)
				report($sformatf("out_z got %h want %h", got.z, want.z));
			if (got.w !== want.w)
				report($sformatf("out_w got %h want %h", got.w, want.w));
			if (got.sat !== want.sat)
				report($sformatf("saturated got %b want %b", got.sat, want.sat));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   burst_left = 0;
	int   n_items = 0;
	int   idle_cycles;

	xform_scoreboard sb = new();

	hte_req_if req ();
	hte_rsp_if rsp ();

	homogeneous_transform_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic put_fields(xf_req_t it);
		req.func       <= it.func;
		req.elem_index <= it.idx;
		req.elem_value <= it.value;
		req.in_x       <= it.x;
		req.in_y       <= it.y;
		req.in_z       <= it.z;
		req.in_w       <= it.w;
	endtask

	// Send one request; open a new burst after a random gap when the current one runs out.
	task automatic push_item(xf_req_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid <= 1'b1;
		put_fields(it);
		do @(posedge clk); while (req.ready !== 1'b1);
		sb.note_request(it);
		if (it.func <= FUNC_READ)
			n_items++;
	endtask

	function automatic xf_req_t make_item(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] i,
			coord_t v, coord_t x, coord_t y, coord_t z, coord_t w);
		xf_req_t it;
		it.func  = f;
		it.idx   = i;
		it.value = v;
		it.x     = x;
		it.y     = y;
		it.z     = z;
		it.w     = w;
		return it;
	endfunction

	function automatic xf_req_t rand_item();
		xf_req_t it;
		it.func  = FUNC_W'($urandom_range(0, FUNC_UNUSED_7));
		it.idx   = IDX_W'($urandom_range(0, 15));
		it.value = $urandom;
		it.x     = $urandom;
		it.y     = $urandom;
		it.z     = $urandom;
		it.w     = $urandom;
		return it;
	endfunction

	// Mostly moderate magnitudes, with extremes and full-range values mixed in.
	function automatic coord_t rand_q(int span);
		case ($urandom_range(0, 9))
			0: return Q_MAX;
			1: return Q_MIN;
			2, 3: return coord_t'($urandom);
			default: return coord_t'(int'($urandom_range(0, 2 * span)) - span);
		endcase
	endfunction

	task automatic run_scene();
		xf_req_t it;
		int      n;
		if ($urandom_range(0, 1)) begin
			it = rand_item();
			it.func = FUNC_IDENT;
			push_item(it);
		end
		n = $urandom_range(0, 6);
		repeat (n) begin
			it = rand_item();
			it.func = FUNC_LOAD_M;
			it.value = rand_q(COEF_SPAN);
			push_item(it);
		end
		n = $urandom_range(0, 1) ? 16 : $urandom_range(0, 4);
		for (int i = 0; i < n; i++) begin
			it = rand_item();
			it.func = FUNC_LOAD_F;
			if (n == 16)
				it.idx = IDX_W'(i);
			it.value = rand_q(COEF_SPAN);
			push_item(it);
		end
		n = $urandom_range(0, 2);
		repeat (n) begin
			it = rand_item();
			it.func = FUNC_COMPOSE;
			push_item(it);
		end
		n = $urandom_range(1, 10);
		repeat (n) begin
			it = rand_item();
			it.func = FUNC_TRANSFORM;
			it.x = rand_q(POINT_SPAN);
			it.y = rand_q(POINT_SPAN);
			it.z = rand_q(POINT_SPAN);
			it.w = rand_q(POINT_SPAN);
			push_item(it);
		end
		n = $urandom_range(0, 3);
		repeat (n) begin
			it = rand_item();
			it.func = FUNC_READ;
			push_item(it);
		end
	endtask

	initial begin
		xf_req_t it;
		int      next_drain;
		req.valid <= 1'b0;
		put_fields('0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity after reset, pass-through of extreme coordinates
		push_item(make_item(FUNC_READ, 4'd0, '0, '0, '0, '0, '0));
		push_item(make_item(FUNC_READ, 4'd15, '0, '0, '0, '0, '0));
		push_item(make_item(FUNC_READ, 4'd1, '0, '0, '0, '0, '0));
		push_item(make_item(FUNC_TRANSFORM, 4'd0, '0, Q_MAX, Q_MIN, -32'sd1, 32'sd1));
		// saturation both ways, and floor on a negative sum
		push_item(make_item(FUNC_LOAD_M, 4'd0, Q_MAX, '0, '0, '0, '0));
		push_item(make_item(FUNC_LOAD_M, 4'd4, Q_MIN, '0, '0, '0, '0));
		push_item(make_item(FUNC_TRANSFORM, 4'd0, '0, Q_MAX, Q_MIN, '0, '0));
		push_item(make_item(FUNC_TRANSFORM, 4'd0, '0, Q_MIN, Q_MAX, '0, '0));
		push_item(make_item(FUNC_TRANSFORM, 4'd0, '0, -32'sd1, '0, 32'sd3, -32'sd65536));
		push_item(make_item(FUNC_READ, 4'd4, '0, '0, '0, '0, '0));
		// compose with clamped elements
		push_item(make_item(FUNC_LOAD_F, 4'd0, 32'sh0002_0000, '0, '0, '0, '0));
		push_item(make_item(FUNC_LOAD_F, 4'd15, Q_MIN, '0, '0, '0, '0));
		push_item(make_item(FUNC_LOAD_F, 4'd6, Q_MAX, '0, '0, '0, '0));
		push_item(make_item(FUNC_COMPOSE, 4'd0, '0, '0, '0, '0, '0));
		push_item(make_item(FUNC_READ, 4'd0, '0, '0, '0, '0, '0));
		push_item(make_item(FUNC_READ, 4'd10, '0, '0, '0, '0, '0));
		// undefined codes must leave the state alone
		push_item(make_item(FUNC_UNUSED_6, 4'd3, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
		push_item(make_item(FUNC_UNUSED_7, 4'd3, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
		push_item(make_item(FUNC_READ, 4'd3, '0, '0, '0, '0, '0));
		push_item(make_item(FUNC_IDENT, 4'd0, '0, '0, '0, '0, '0));
		push_item(make_item(FUNC_LOAD_F, 4'd1, 32'shFFFF_8000, '0, '0, '0, '0));
		push_item(make_item(FUNC_COMPOSE, 4'd0, '0, '0, '0, '0, '0));
		push_item(make_item(FUNC_TRANSFORM, 4'd0, '0, 32'sh0001_8000, 32'shFFFD_C000,
			32'sh0000_C000, Q_ONE));
		push_item(make_item(FUNC_READ, 4'd1, '0, '0, '0, '0, '0));

		n_items = 0;
		next_drain = DRAIN_EVERY;
		while (n_items < RANDOM_ITEMS) begin
			if (n_items >= next_drain) begin
				// hold off until the engine has returned everything
				req.valid <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
				next_drain += DRAIN_EVERY;
			end
			if ($urandom_range(0, 4) == 0) begin
				it = rand_item();
				push_item(it);
			end else begin
				run_scene();
			end
		end

		req.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Receiver stalls follow their own pattern, switched whenever the current random hold runs out.
	initial begin
		int          hold;
		stall_mode_t mode;
		hold = 0;
		mode = STALL_NONE;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				hold = $urandom_range(4, 40);
			end
			hold--;
			case (mode)
				STALL_NONE: rsp.ready <= 1'b1;
				STALL_RANDOM: rsp.ready <= ($urandom_range(0, 3) != 0);
				STALL_HOLD: rsp.ready <= 1'b0;
				default: rsp.ready <= hold[0];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
			sb.check_response(xf_rsp_t'{rsp.out_x, rsp.out_y, rsp.out_z, rsp.out_w,
				rsp.saturated});
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req.valid === 1'b1 && req.ready === 1'b1) ||
					(rsp.valid === 1'b1 && rsp.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

endmodule
